/* rtl/h2r_pkg.sv */
// Shared types and constants for the HSL to RGB converter.
// Holds the item structs, the fraction format and the hue sector codes.
// No dependencies.
package h2r_pkg;

   // Fraction format: ONE = 2^FRAC_BITS stands for 1.0
   localparam int FRAC_BITS = 12;
   localparam int FIELD_W   = FRAC_BITS + 1;
   localparam int HUE_W     = 16;

   // One input item
   typedef struct packed {
      logic signed [HUE_W-1:0]   hue;
      logic        [FIELD_W-1:0] saturation;
      logic        [FIELD_W-1:0] lightness;
      logic        [FIELD_W-1:0] alpha_in;
   } hsl_req_type;

   // One result item
   typedef struct packed {
      logic [FIELD_W-1:0] red;
      logic [FIELD_W-1:0] green;
      logic [FIELD_W-1:0] blue;
      logic [FIELD_W-1:0] alpha_out;
   } rgb_rsp_type;

   // 60 degree hue sectors, named by the colour pair they run between
   typedef enum logic [2:0] {
      SEC_RED_YELLOW     = 3'd0,
      SEC_YELLOW_GREEN   = 3'd1,
      SEC_GREEN_CYAN     = 3'd2,
      SEC_CYAN_BLUE      = 3'd3,
      SEC_BLUE_MAGENTA   = 3'd4,
      SEC_MAGENTA_RED    = 3'd5
   } sector_type;

endpackage

/* rtl/hsl_to_rgb_converter.sv */
// Top level of the HSL to RGB converter: five-stage pipeline, one item per clock.
// Depends on h2r_pkg for the item structs, fraction format and sector codes.
//
//   channel | ports                        | handshake
//   --------+------------------------------+---------------------------------
//   request | start, busy, req_data        | taken when start high, busy low
//   result  | rsp_strobe, rsp_data         | one-cycle strobe, never held off
//
// Throughput is one item per clock; busy is always low.
// The result strobe rises once the item has passed the five register stages
// (hue sector, chroma product, channel terms, channel sums, divide by 15 and
// clamp).
// Synchronous reset clears the stage valid bits only; items in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module hsl_to_rgb_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  h2r_pkg::hsl_req_type req_data,
   output logic                 rsp_strobe,
   output h2r_pkg::rgb_rsp_type rsp_data
);

   localparam int FB    = h2r_pkg::FRAC_BITS;
   localparam int FW    = h2r_pkg::FIELD_W;
   localparam int CNW   = 2 * FB + 1;          // chroma at scale ONE*ONE
   localparam int VW    = 2 * FB + 12;         // channel value at scale ONE*ONE*960
   localparam int ZW    = VW - FB - 6;         // value after dividing by ONE*64
   localparam int D15_S = ZW + 4;
   localparam int D15_MW = D15_S - 3;
   localparam int D15_M = (1 << D15_S) / 15 + 1;
   localparam int QW    = ZW - 3;
   localparam int LAT   = 5;

   localparam logic [FW-1:0] ONE = FW'(1) << FB;

   // hue sector search: divide (u >> 6) by 15 with a reciprocal
   localparam int HSEC_S = 15;
   localparam logic [11:0] HSEC_M = 12'd2185;

   // ---------------- stage 1: clamp, wrap hue, find 60 degree slot ----------
   logic          s1_valid_ff;
   logic [16:0]   s1_u_in, s1_u_ff;
   logic [6:0]    s1_sec_in, s1_sec_ff;
   logic [FW-1:0] s1_sat_in, s1_sat_ff;
   logic [FW-1:0] s1_light_in, s1_light_ff;
   logic [FW-1:0] s1_alpha_in, s1_alpha_ff;
   logic [FW-1:0] s1_t_in, s1_t_ff;
   logic [22:0]   s1_hprod;
   logic [FW:0]   s1_twol;
   logic [FW:0]   s1_absd;
   logic          accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      // shift hue up by six full turns so the value is never negative
      s1_u_in   = 17'({~req_data.hue[15], req_data.hue[14:0]}) + 17'd1792;
      s1_hprod  = 23'(s1_u_in[16:6]) * 23'(HSEC_M);
      s1_sec_in = s1_hprod[HSEC_S +: 7];

      s1_sat_in   = (req_data.saturation > ONE) ? ONE : req_data.saturation;
      s1_light_in = (req_data.lightness > ONE) ? ONE : req_data.lightness;
      s1_alpha_in = (req_data.alpha_in > ONE) ? ONE : req_data.alpha_in;

      s1_twol = {s1_light_in, 1'b0};
      s1_absd = (s1_twol >= (FW+1)'(ONE)) ? s1_twol - (FW+1)'(ONE)
                                           : (FW+1)'(ONE) - s1_twol;
      s1_t_in = ONE - s1_absd[FW-1:0];
   end

   // ---------------- stage 2: sector, secondary weight, chroma --------------
   logic                s2_valid_ff;
   logic [12:0]         s2_qprod;
   logic [3:0]          s2_turns;
   logic [6:0]          s2_secnum;
   logic [16:0]         s2_rem_full;
   logic [9:0]          s2_rem;
   h2r_pkg::sector_type s2_sector_in, s2_sector_ff;
   logic [9:0]          s2_k_in, s2_k_ff;
   logic [CNW-1:0]      s2_cn_in, s2_cn_ff;
   logic [FW-1:0]       s2_light_ff;
   logic [FW-1:0]       s2_alpha_ff;
   logic [2*FW-1:0]     s2_tprod;

   always_comb begin
      // sec mod 6 through a reciprocal of 6 (exact below 96)
      s2_qprod     = 13'(s1_sec_ff) * 13'd43;
      s2_turns     = s2_qprod[8 +: 4];
      s2_secnum    = s1_sec_ff - 7'(s2_turns) * 7'd6;
      s2_sector_in = h2r_pkg::sector_type'(s2_secnum[2:0]);
      s2_rem_full  = s1_u_ff - 17'(s1_sec_ff) * 17'd960;
      s2_rem       = s2_rem_full[9:0];
      // odd sectors run the secondary weight downwards
      s2_k_in      = s2_secnum[0] ? 10'd960 - s2_rem : s2_rem;
      s2_tprod     = (2*FW)'(s1_t_ff) * (2*FW)'(s1_sat_ff);
      s2_cn_in     = s2_tprod[CNW-1:0];
   end

   // ---------------- stage 3: channel terms at scale ONE*ONE*960 ------------
   logic                s3_valid_ff;
   logic [VW-1:0]       s3_cv_in, s3_cv_ff;
   logic [VW-1:0]       s3_xv_in, s3_xv_ff;
   logic [VW-1:0]       s3_base_in, s3_base_ff;
   h2r_pkg::sector_type s3_sector_ff;
   logic [FW-1:0]       s3_alpha_ff;

   always_comb begin
      s3_cv_in   = VW'(s2_cn_ff) * VW'(10'd960);
      s3_xv_in   = VW'(s2_cn_ff) * VW'(s2_k_ff);
      // offset m plus the rounding half, both halved with the channel terms
      s3_base_in = (VW'(s2_light_ff) << FB) * VW'(10'd960)
                 + (VW'(ONE) * VW'(9'd480))
                 - VW'(s2_cn_ff) * VW'(9'd480);
   end

   // ---------------- stage 4: pick ordering, add offset, drop ONE*64 --------
   logic          s4_valid_ff;
   logic [VW-1:0] s4_rpick, s4_gpick, s4_bpick;
   logic [VW-1:0] s4_rsum, s4_gsum, s4_bsum;
   logic [ZW-1:0] s4_red_in, s4_red_ff;
   logic [ZW-1:0] s4_green_in, s4_green_ff;
   logic [ZW-1:0] s4_blue_in, s4_blue_ff;
   logic [FW-1:0] s4_alpha_ff;

   always_comb begin
      s4_rpick = '0;
      s4_gpick = '0;
      s4_bpick = '0;
      case (s3_sector_ff)
         h2r_pkg::SEC_RED_YELLOW: begin
            s4_rpick = s3_cv_ff;
            s4_gpick = s3_xv_ff;
         end
         h2r_pkg::SEC_YELLOW_GREEN: begin
            s4_rpick = s3_xv_ff;
            s4_gpick = s3_cv_ff;
         end
         h2r_pkg::SEC_GREEN_CYAN: begin
            s4_gpick = s3_cv_ff;
            s4_bpick = s3_xv_ff;
         end
         h2r_pkg::SEC_CYAN_BLUE: begin
            s4_gpick = s3_xv_ff;
            s4_bpick = s3_cv_ff;
         end
         h2r_pkg::SEC_BLUE_MAGENTA: begin
            s4_rpick = s3_xv_ff;
            s4_bpick = s3_cv_ff;
         end
         default: begin
            s4_rpick = s3_cv_ff;
            s4_bpick = s3_xv_ff;
         end
      endcase
      s4_rsum     = s3_base_ff + s4_rpick;
      s4_gsum     = s3_base_ff + s4_gpick;
      s4_bsum     = s3_base_ff + s4_bpick;
      s4_red_in   = s4_rsum[VW-1:FB+6];
      s4_green_in = s4_gsum[VW-1:FB+6];
      s4_blue_in  = s4_bsum[VW-1:FB+6];
   end

   // ---------------- stage 5: divide by 15, clamp, output register ----------
   logic [ZW+D15_MW-1:0] s5_rprod, s5_gprod, s5_bprod;
   logic [QW-1:0]        s5_rq, s5_gq, s5_bq;
   logic                 rsp_strobe_ff;
   h2r_pkg::rgb_rsp_type rsp_data_in, rsp_data_ff;

   always_comb begin
      s5_rprod = (ZW+D15_MW)'(s4_red_ff)   * (ZW+D15_MW)'(D15_M);
      s5_gprod = (ZW+D15_MW)'(s4_green_ff) * (ZW+D15_MW)'(D15_M);
      s5_bprod = (ZW+D15_MW)'(s4_blue_ff)  * (ZW+D15_MW)'(D15_M);
      s5_rq    = s5_rprod[D15_S +: QW];
      s5_gq    = s5_gprod[D15_S +: QW];
      s5_bq    = s5_bprod[D15_S +: QW];
      rsp_data_in.red       = (s5_rq > QW'(ONE)) ? ONE : s5_rq[FW-1:0];
      rsp_data_in.green     = (s5_gq > QW'(ONE)) ? ONE : s5_gq[FW-1:0];
      rsp_data_in.blue      = (s5_bq > QW'(ONE)) ? ONE : s5_bq[FW-1:0];
      rsp_data_in.alpha_out = s4_alpha_ff;
   end

   // ---------------- registers ----------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= accept;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         s4_valid_ff   <= s3_valid_ff;
         rsp_strobe_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_u_ff      <= s1_u_in;
      s1_sec_ff    <= s1_sec_in;
      s1_sat_ff    <= s1_sat_in;
      s1_light_ff  <= s1_light_in;
      s1_alpha_ff  <= s1_alpha_in;
      s1_t_ff      <= s1_t_in;

      s2_sector_ff <= s2_sector_in;
      s2_k_ff      <= s2_k_in;
      s2_cn_ff     <= s2_cn_in;
      s2_light_ff  <= s1_light_ff;
      s2_alpha_ff  <= s1_alpha_ff;

      s3_cv_ff     <= s3_cv_in;
      s3_xv_ff     <= s3_xv_in;
      s3_base_ff   <= s3_base_in;
      s3_sector_ff <= s2_sector_ff;
      s3_alpha_ff  <= s2_alpha_ff;

      s4_red_ff    <= s4_red_in;
      s4_green_ff  <= s4_green_in;
      s4_blue_ff   <= s4_blue_in;
      s4_alpha_ff  <= s3_alpha_ff;

      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   a_item_reaches_output: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_strobe)
      else $error("accepted item did not produce a result after the pipeline latency");

   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("result strobe without an item taken at the matching cycle");

   a_channels_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.red <= ONE) && (rsp_data.green <= ONE)
                     && (rsp_data.blue <= ONE) && (rsp_data.alpha_out <= ONE))
      else $error("result channel above one");

   a_stage_weight_bounded: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_k_ff <= 10'd960) && (s2_cn_ff <= CNW'(ONE) * CNW'(ONE)))
      else $error("secondary weight or chroma out of range");
`endif

endmodule
